/* src/gddr_pkg.sv */
// Shared types, constants and helper functions of the grid DDA ray caster.
`timescale 1ns / 1ps
package gddr_pkg;

  // Map and screen geometry.
  localparam int MapDim    = 8;
  localparam int CellW     = 3;
  localparam int ColW      = 9;
  localparam int ScreenCols = 512;

  // Fixed-point widths.
  localparam int RdW   = 18;  // ray component, signed Q.14
  localparam int MagW  = 17;  // magnitude of a ray component
  localparam int DistW = 24;  // distances, unsigned Q8.16
  localparam int NumW  = 34;  // dividend width of the shared divider
  localparam int LhW   = 15;  // line height

  localparam logic [DistW-1:0] DMax  = {DistW{1'b1}};
  localparam logic [LhW-1:0]   LhMax = {LhW{1'b1}};

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CAM_POS_X   = 3'd0,
    REG_CAM_POS_Y   = 3'd1,
    REG_VIEW_DIR_X  = 3'd2,
    REG_VIEW_DIR_Y  = 3'd3,
    REG_CAM_PLANE_X = 3'd4,
    REG_CAM_PLANE_Y = 3'd5,
    REG_WALL_MAP    = 3'd6,
    REG_VIEW_HEIGHT = 3'd7
  } gddr_reg_e;

  // Configuration seen by the front and the back.
  typedef struct packed {
    logic [15:0]        cam_pos_x;
    logic [15:0]        cam_pos_y;
    logic signed [15:0] view_dir_x;
    logic signed [15:0] view_dir_y;
    logic signed [15:0] cam_plane_x;
    logic signed [15:0] cam_plane_y;
    logic [63:0]        wall_map;
    logic [10:0]        view_height;
  } gddr_cfg_t;

  // One classified ray waiting for the back end.
  typedef struct packed {
    logic [ColW-1:0]     column;
    logic signed [RdW-1:0] rdx;
    logic signed [RdW-1:0] rdy;
  } gddr_ray_t;

  // Divider request and reply.
  typedef struct packed {
    logic             start;
    logic [NumW-1:0]  num;
    logic [DistW-1:0] den;
  } gddr_div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
  } gddr_div_rsp_t;

  // Magnitude of a ray component.
  function automatic logic [MagW-1:0] ray_mag(input logic signed [RdW-1:0] v);
    logic signed [RdW-1:0] a;
    a = v[RdW-1] ? -v : v;
    return a[MagW-1:0];
  endfunction

  // Saturate a quotient to the distance range.
  function automatic logic [DistW-1:0] sat_dist(input logic [NumW-1:0] v);
    return (v > NumW'(DMax)) ? DMax : v[DistW-1:0];
  endfunction

  // Cells outside the map count as wall.
  function automatic logic cell_is_wall(input logic signed [4:0] x,
                                        input logic signed [4:0] y,
                                        input logic [63:0] map);
    logic outside;
    outside = (x < 5'sd0) || (y < 5'sd0) ||
              (x > 5'(MapDim - 1)) || (y > 5'(MapDim - 1));
    return outside ? 1'b1 : map[{y[CellW-1:0], x[CellW-1:0]}];
  endfunction

endpackage

/* src/gddr_front.sv */
// Front end: accepts a column and computes the ray direction for it.
`timescale 1ns / 1ps
module gddr_front import gddr_pkg::*; (
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gddr_cfg_t cfg_i,
  input  logic [ColW-1:0] column_i,
  output logic      push_o,
  output gddr_ray_t ray_o,
  input  logic      full_i
);

  logic signed [10:0] off;
  logic signed [26:0] prod_x, prod_y, adj_x, adj_y;

  // Column offset 2*column - W, then plane*offset/W truncated toward zero.
  always_comb begin
    off    = $signed({1'b0, column_i, 1'b0}) - 11'sd512;
    prod_x = 27'(cfg_i.cam_plane_x) * 27'(off);
    prod_y = 27'(cfg_i.cam_plane_y) * 27'(off);
    adj_x  = prod_x + (prod_x[26] ? 27'sd511 : 27'sd0);
    adj_y  = prod_y + (prod_y[26] ? 27'sd511 : 27'sd0);
    ray_o.column = column_i;
    ray_o.rdx    = RdW'(cfg_i.view_dir_x) + RdW'(adj_x >>> 9);
    ray_o.rdy    = RdW'(cfg_i.view_dir_y) + RdW'(adj_y >>> 9);
  end

  // A transfer goes straight into the queue.
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

/* src/gddr_fifo.sv */
// Two-entry queue between the front and the back end.
`timescale 1ns / 1ps
module gddr_fifo import gddr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  gddr_ray_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output gddr_ray_t data_o
);

  gddr_ray_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* src/gddr_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gddr_div import gddr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gddr_div_req_t req_i,
  output gddr_div_rsp_t rsp_o
);

  logic [NumW-1:0]  quot_q;
  logic [DistW-1:0] rem_q, den_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [DistW:0]   shifted, diff;
  logic             take;

  // One trial subtraction; a zero divisor yields all ones.
  always_comb begin
    shifted = {rem_q, quot_q[NumW-1]};
    diff    = shifted - {1'b0, den_q};
    take    = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      quot_q <= {quot_q[NumW-2:0], take};
      rem_q  <= take ? diff[DistW-1:0] : shifted[DistW-1:0];
    end
  end

  // Iteration count and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= 6'(NumW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* src/gddr_back.sv */
// Back end: reciprocal distances, DDA walk, wall distance and span.
`timescale 1ns / 1ps
module gddr_back import gddr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gddr_cfg_t     cfg_i,
  input  logic          ray_valid_i,
  input  gddr_ray_t     ray_i,
  output logic          pop_o,
  output gddr_div_req_t div_req_o,
  input  gddr_div_rsp_t div_rsp_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [47:0]   out_data_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DX   = 8'b0000_0010,
    S_DY   = 8'b0000_0100,
    S_SIDE = 8'b0000_1000,
    S_WALK = 8'b0001_0000,
    S_PERP = 8'b0010_0000,
    S_HGT  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  gddr_ray_t          ray_q;
  logic [DistW-1:0]   dx_q, dy_q, sdx_q, sdy_q;
  logic signed [4:0]  mx_q, my_q;
  logic               side_q, moved_q;
  logic [LhW-1:0]     lh_q;
  logic               out_valid_q;
  logic [47:0]        out_data_q;

  logic [13:0]        fx, fy, fsel_x, fsel_y;
  logic [37:0]        side_px, side_py;
  logic [DistW:0]     sum_x, sum_y;
  logic               wall;
  logic signed [4:0]  hit_cell;
  logic               neg;
  logic signed [18:0] edge_pos, diff;
  logic [16:0]        diff_mag;
  logic [MagW-1:0]    rm;
  logic [15:0]        top_w, bot_w;
  logic               out_free;

  // Initial side distances from the fractional camera position.
  always_comb begin
    fx      = {1'b0, cfg_i.cam_pos_x[12:0]};
    fy      = {1'b0, cfg_i.cam_pos_y[12:0]};
    fsel_x  = ray_q.rdx[RdW-1] ? fx : 14'd8192 - fx;
    fsel_y  = ray_q.rdy[RdW-1] ? fy : 14'd8192 - fy;
    side_px = 38'(fsel_x) * 38'(dx_q);
    side_py = 38'(fsel_y) * 38'(dy_q);
  end

  // Saturating DDA advance and wall test.
  always_comb begin
    sum_x = {1'b0, sdx_q} + {1'b0, dx_q};
    sum_y = {1'b0, sdy_q} + {1'b0, dy_q};
    wall  = cell_is_wall(mx_q, my_q, cfg_i.wall_map);
  end

  // Distance from the camera to the crossed cell edge.
  always_comb begin
    hit_cell = side_q ? my_q : mx_q;
    neg      = side_q ? ray_q.rdy[RdW-1] : ray_q.rdx[RdW-1];
    rm       = side_q ? ray_mag(ray_q.rdy) : ray_mag(ray_q.rdx);
    edge_pos = {6'(hit_cell) + 6'(neg), 13'd0};
    diff     = edge_pos - $signed({3'b0, side_q ? cfg_i.cam_pos_y : cfg_i.cam_pos_x});
    diff_mag = diff[18] ? 17'(-diff) : diff[16:0];
  end

  // Vertical span around the screen center.
  always_comb begin
    top_w = {6'd0, cfg_i.view_height[10:1]} - {2'd0, lh_q[LhW-1:1]};
    bot_w = {6'd0, cfg_i.view_height[10:1]} + {2'd0, lh_q[LhW-1:1]};
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: next state, divider requests and queue pops.
  always_comb begin
    state_d       = state_q;
    pop_o         = 1'b0;
    div_req_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (ray_valid_i) begin
          pop_o           = 1'b1;
          div_req_o.start = 1'b1;
          div_req_o.num   = NumW'(1) << 30;
          div_req_o.den   = DistW'(ray_mag(ray_i.rdx));
          state_d         = S_DX;
        end
      end
      S_DX: begin
        if (div_rsp_i.done) begin
          div_req_o.start = 1'b1;
          div_req_o.num   = NumW'(1) << 30;
          div_req_o.den   = DistW'(ray_mag(ray_q.rdy));
          state_d         = S_DY;
        end
      end
      S_DY: begin
        if (div_rsp_i.done) state_d = S_SIDE;
      end
      S_SIDE: state_d = S_WALK;
      S_WALK: begin
        if (wall) begin
          div_req_o.start = 1'b1;
          if (moved_q) begin
            div_req_o.num = {diff_mag, 17'd0};
            div_req_o.den = DistW'(rm);
            state_d       = S_PERP;
          end else begin
            // No step taken: a zero divisor gives the largest line height.
            div_req_o.num = NumW'({cfg_i.view_height, 16'd0});
            div_req_o.den = '0;
            state_d       = S_HGT;
          end
        end
      end
      S_PERP: begin
        if (div_rsp_i.done) begin
          div_req_o.start = 1'b1;
          div_req_o.num   = NumW'({cfg_i.view_height, 16'd0});
          div_req_o.den   = sat_dist(div_rsp_i.quot);
          state_d         = S_HGT;
        end
      end
      S_HGT: begin
        if (div_rsp_i.done) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) ray_q <= ray_i;
    if (state_q == S_DX && div_rsp_i.done) dx_q <= sat_dist(div_rsp_i.quot);
    if (state_q == S_DY && div_rsp_i.done) dy_q <= sat_dist(div_rsp_i.quot);
    if (state_q == S_SIDE) begin
      sdx_q   <= sat_dist(NumW'(side_px >> 13));
      sdy_q   <= sat_dist(NumW'(side_py >> 13));
      mx_q    <= $signed({2'b0, cfg_i.cam_pos_x[15:13]});
      my_q    <= $signed({2'b0, cfg_i.cam_pos_y[15:13]});
      side_q  <= 1'b0;
      moved_q <= 1'b0;
    end
    if (state_q == S_WALK && !wall) begin
      moved_q <= 1'b1;
      if (sdx_q < sdy_q) begin
        sdx_q  <= sum_x[DistW] ? DMax : sum_x[DistW-1:0];
        mx_q   <= ray_q.rdx[RdW-1] ? mx_q - 5'sd1 : mx_q + 5'sd1;
        side_q <= 1'b0;
      end else begin
        sdy_q  <= sum_y[DistW] ? DMax : sum_y[DistW-1:0];
        my_q   <= ray_q.rdy[RdW-1] ? my_q - 5'sd1 : my_q + 5'sd1;
        side_q <= 1'b1;
      end
    end
    if (state_q == S_HGT && div_rsp_i.done) begin
      lh_q <= (div_rsp_i.quot > NumW'(LhMax)) ? LhMax : div_rsp_i.quot[LhW-1:0];
    end
    if (state_q == S_FIN && out_free) begin
      out_data_q <= {2'b0, my_q[CellW-1:0], mx_q[CellW-1:0], side_q,
                     bot_w[14:0], top_w[14:0], ray_q.column};
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/grid_dda_ray_caster.sv */
// Top level of the grid DDA ray caster: configuration registers and the two halves.
//
// Usage: write the camera, map and screen height through the cfg_* port while the
// block is idle (one register per cycle with cfg_we_i high; no read-back). Send
// screen column indexes on the s_axis stream; for each column one result leaves
// on the m_axis stream with the wall span, the side crossed last and the hit cell.
// The front computes the ray direction in the transfer cycle and parks it in a
// two-entry queue, so up to two further columns are taken while one is traced.
// The back traces one ray at a time: the shared bit-serial divider gives the two step
// distances, the DDA walk (at most about 16 steps on the 8 x 8 map) looks for a wall,
// and the divider then gives the wall distance and the line height; when the camera
// starts in a wall the walk takes no step and the wall distance pass is skipped.
// Results sit in an output register; while the receiver holds m_axis_tready low
// the result is held, the back stalls at its last step and the queue fills, after
// which s_axis_tready falls. Reset empties the queue, drops m_axis_tvalid and
// loads the default camera (position 3,3 looking along -x, plane 0.66, empty map,
// height 500).
`timescale 1ns / 1ps
module grid_dda_ray_caster import gddr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [8:0] column, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [8:0] out_column, [23:9] span_top, [38:24] span_bottom, [39] hit_side,
  // [42:40] hit_cell_x, [45:43] hit_cell_y, rest zero
  output logic [47:0] m_axis_tdata
);

  gddr_cfg_t     cfg_q;
  logic          push, full, pop, ray_valid;
  gddr_ray_t     ray_in, ray_out;
  gddr_div_req_t div_req;
  gddr_div_rsp_t div_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_pos_x   <= 16'd24576;
      cfg_q.cam_pos_y   <= 16'd24576;
      cfg_q.view_dir_x  <= -16'sd16384;
      cfg_q.view_dir_y  <= 16'sd0;
      cfg_q.cam_plane_x <= 16'sd0;
      cfg_q.cam_plane_y <= 16'sd10813;
      cfg_q.wall_map    <= 64'd0;
      cfg_q.view_height <= 11'd500;
    end else if (cfg_we_i) begin
      case (gddr_reg_e'(cfg_idx_i))
        REG_CAM_POS_X:   cfg_q.cam_pos_x   <= cfg_data_i[15:0];
        REG_CAM_POS_Y:   cfg_q.cam_pos_y   <= cfg_data_i[15:0];
        REG_VIEW_DIR_X:  cfg_q.view_dir_x  <= cfg_data_i[15:0];
        REG_VIEW_DIR_Y:  cfg_q.view_dir_y  <= cfg_data_i[15:0];
        REG_CAM_PLANE_X: cfg_q.cam_plane_x <= cfg_data_i[15:0];
        REG_CAM_PLANE_Y: cfg_q.cam_plane_y <= cfg_data_i[15:0];
        REG_WALL_MAP:    cfg_q.wall_map    <= cfg_data_i;
        REG_VIEW_HEIGHT: cfg_q.view_height <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  gddr_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cfg_i      (cfg_q),
    .column_i   (s_axis_tdata[ColW-1:0]),
    .push_o     (push),
    .ray_o      (ray_in),
    .full_i     (full)
  );

  gddr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ray_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (ray_valid),
    .data_o  (ray_out)
  );

  gddr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gddr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ray_valid_i (ray_valid),
    .ray_i       (ray_out),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
